// File: sv/fnv_pkg.sv
// shared types, constants and prime multiply helpers for the fnv-1a hash engine
package fnv_pkg;

  localparam int unsigned HashW   = 128;
  localparam int unsigned HalfW   = 64;
  localparam int unsigned ByteW   = 8;

  // wide_mode register codes
  localparam logic Mode64  = 1'b0;
  localparam logic Mode128 = 1'b1;

  localparam logic [HalfW-1:0] Basis64   = 64'd14695981039346656037;
  localparam logic [HalfW-1:0] Basis128H = 64'd7809847782465536322;
  localparam logic [HalfW-1:0] Basis128L = 64'd7113472399480571277;

  typedef logic [HashW-1:0] hash_t;
  typedef logic [HalfW-1:0] half_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             has_byte;
    logic             first_byte;
    logic             last_byte;
  } item_t;

  // x * 0x100000001b3 mod 2^64, prime bits are 40, 8, 7, 5, 4, 1, 0
  function automatic half_t mul_prime64(input half_t x);
    half_t r;
    r = x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
    return r;
  endfunction

  // x * (2^88 + 315) mod 2^128, 315 bits are 8, 5, 4, 3, 1, 0
  function automatic hash_t mul_prime128(input hash_t x);
    hash_t r;
    r = x + (x << 1) + (x << 3) + (x << 4) + (x << 5) + (x << 8) + (x << 88);
    return r;
  endfunction

endpackage

// File: sv/fnv_if.sv
// handshake channels: byte input, digest output and config write
interface fnv_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        has_byte;
  logic        first_byte;
  logic        last_byte;

  modport source (output valid, output data_byte, output has_byte, output first_byte,
                  output last_byte, input ready);
  modport sink   (input valid, input data_byte, input has_byte, input first_byte,
                  input last_byte, output ready);
endinterface

interface fnv_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_low;
  logic [63:0] digest_high;

  modport source (output valid, output digest_low, output digest_high, input ready);
  modport sink   (input valid, input digest_low, input digest_high, output ready);
endinterface

interface fnv_cfg_if;
  logic        valid;
  logic        ready;
  logic        wide_mode;

  modport source (output valid, output wide_mode, input ready);
  modport sink   (input valid, input wide_mode, output ready);
endinterface

// File: sv/fnv_step.sv
// one fnv-1a absorb step: basis load, byte xor and prime multiply
module fnv_step (
  input  fnv_pkg::hash_t state,
  input  logic           wide,
  input  fnv_pkg::item_t item,
  output fnv_pkg::hash_t state_next,
  output fnv_pkg::half_t digest_low,
  output fnv_pkg::half_t digest_high
);

  fnv_pkg::hash_t base;
  fnv_pkg::hash_t mixed;
  fnv_pkg::half_t lo64;

  always_comb begin
    base = state;
    if (item.first_byte) begin
      if (wide) begin
        base = {fnv_pkg::Basis128H, fnv_pkg::Basis128L};
      end else begin
        base = {{fnv_pkg::HalfW{1'b0}}, fnv_pkg::Basis64};
      end
    end
    mixed = {base[fnv_pkg::HashW-1:fnv_pkg::ByteW],
             base[fnv_pkg::ByteW-1:0] ^ item.data_byte};
    lo64 = fnv_pkg::mul_prime64(mixed[fnv_pkg::HalfW-1:0]);
    state_next = base;
    if (item.has_byte) begin
      if (wide) begin
        state_next = fnv_pkg::mul_prime128(mixed);
      end else begin
        state_next = {{fnv_pkg::HalfW{1'b0}}, lo64};
      end
    end
  end

  assign digest_low  = state_next[fnv_pkg::HalfW-1:0];
  assign digest_high = wide ? state_next[fnv_pkg::HashW-1:fnv_pkg::HalfW]
                            : {fnv_pkg::HalfW{1'b0}};

endmodule

// File: sv/fnv1a_hash_engine.sv
// Streaming FNV-1a hash, 64 or 128 bits wide as set by wide_mode (reset 1).
// Bytes are taken one per cycle while no last beat is held back: a beat lands
// in an input register, from which a shift-add prime multiply updates the
// 128-bit state and, on a last beat, loads the digest register. Only a last
// beat that finds the digest register still full waits for the output side;
// other beats pass.
// The state is kept after a digest, so a beat without first continues the hash.
module fnv1a_hash_engine (
  input  logic      clk,
  input  logic      rst,
  fnv_in_if.sink    byte_ch,
  fnv_cfg_if.sink   cfg,
  fnv_out_if.source digest_ch
);

  logic           wide_mode;
  logic           s1_valid;
  fnv_pkg::item_t s1_item;
  fnv_pkg::hash_t hash_state;
  fnv_pkg::hash_t hash_state_next;
  fnv_pkg::half_t dig_low_next;
  fnv_pkg::half_t dig_high_next;
  logic           s1_advance;
  logic           out_valid;
  fnv_pkg::half_t out_low;
  fnv_pkg::half_t out_high;

  assign cfg.ready = 1'b1;

  // a last beat must wait while an unread digest sits in the output register
  assign s1_advance   = s1_valid && !(s1_item.last_byte && out_valid && !digest_ch.ready);
  assign byte_ch.ready = !s1_valid || s1_advance;

  fnv_step u_step (
    .state       (hash_state),
    .wide        (wide_mode),
    .item        (s1_item),
    .state_next  (hash_state_next),
    .digest_low  (dig_low_next),
    .digest_high (dig_high_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_mode  <= fnv_pkg::Mode128;
      s1_valid   <= 1'b0;
      hash_state <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        wide_mode <= cfg.wide_mode;
      end
      if (byte_ch.valid && byte_ch.ready) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        hash_state <= hash_state_next;
      end
      if (s1_advance && s1_item.last_byte) begin
        out_valid <= 1'b1;
      end else if (digest_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (byte_ch.valid && byte_ch.ready) begin
      s1_item.data_byte  <= byte_ch.data_byte;
      s1_item.has_byte   <= byte_ch.has_byte;
      s1_item.first_byte <= byte_ch.first_byte;
      s1_item.last_byte  <= byte_ch.last_byte;
    end
    if (s1_advance && s1_item.last_byte) begin
      out_low  <= dig_low_next;
      out_high <= dig_high_next;
    end
  end

  assign digest_ch.valid       = out_valid;
  assign digest_ch.digest_low  = out_low;
  assign digest_ch.digest_high = out_high;

endmodule
